### design/dssa_pkg.sv
// Package for the dual stack shared array unit.
// Holds operation and status codes and field widths; no dependencies.
// Used by the channel interfaces and by the top level.
package dssa_pkg;

    // Payload field widths
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // Operation codes; the unused fourth code behaves as a peek
    localparam op_t OP_PUSH = 2'd0;
    localparam op_t OP_POP  = 2'd1;
    localparam op_t OP_PEEK = 2'd2;

    // Status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_OVERFLOW = 2'd1;
    localparam status_t ST_EMPTY    = 2'd2;

endpackage

### design/dssa_if.sv
// Channel interfaces for the dual stack shared array unit.
// Request and response channels with valid/ready handshakes.
// Depends on dssa_pkg for the payload types.
interface dssa_req_if;
    import dssa_pkg::*;

    logic    valid;
    logic    ready;
    op_t     op;
    logic    stack_sel;
    data_t   push_value;

    modport source (output valid, output op, output stack_sel, output push_value,
                    input ready);
    modport sink   (input valid, input op, input stack_sel, input push_value,
                    output ready);
endinterface

interface dssa_rsp_if;
    import dssa_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    data_t   top_value;
    logic    lower_empty;
    logic    upper_empty;
    logic    store_full;

    modport source (output valid, output status, output top_value, output lower_empty,
                    output upper_empty, output store_full, input ready);
    modport sink   (input valid, input status, input top_value, input lower_empty,
                    input upper_empty, input store_full, output ready);
endinterface

### design/dual_stack_shared_array_unit.sv
// A request beat is registered with its read data and pending state, then moved into the
// output register once that register is free; no new request is taken until then. Each request
// updates the counts and accesses the store when accepted, and the output register then picks up the read data.
// Reset clears both stack counts and the handshake state; store contents are not cleared
// and need no clearing pass, since only entries written by a push are ever returned.
// Depends on dssa_pkg and the channel interfaces in dssa_if.sv.
module dual_stack_shared_array_unit #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dssa_req_if.sink    req,
    dssa_rsp_if.source  rsp
);
    import dssa_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_SUM = (CW + 1)'(CAPACITY);

    // Stack state and request bookkeeping
    logic [CW-1:0] lower_count_reg, lower_count_next;
    logic [CW-1:0] upper_count_reg, upper_count_next;
    logic          busy_reg;
    status_t       pend_status_reg;
    logic          pend_fwd_reg;
    logic          pend_zero_reg;
    data_t         pend_value_reg;

    // Output register
    logic          out_valid_reg;
    status_t       out_status_reg;
    data_t         out_top_reg;
    logic          out_lower_empty_reg;
    logic          out_upper_empty_reg;
    logic          out_full_reg;

    // Store
    data_t         mem [CAPACITY];
    data_t         rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    logic          accept;
    logic          out_load;
    logic [CW:0]   count_sum;
    logic          store_full;
    logic [CW-1:0] sel_count;
    logic [CW-1:0] new_sel_count;
    logic          sel_empty;
    status_t       status_c;
    logic [CW-1:0] waddr_wide;
    logic [CW-1:0] raddr_wide;

    assign accept   = req.valid && req.ready;
    assign req.ready = !busy_reg;
    assign out_load = busy_reg && (!out_valid_reg || rsp.ready);

    // Decode the request against the current counts
    always_comb
    begin
        count_sum     = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
        store_full    = (count_sum >= CAP_SUM);
        sel_count     = req.stack_sel ? upper_count_reg : lower_count_reg;
        sel_empty     = (sel_count == '0);
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        mem_we        = 1'b0;
        status_c      = ST_OK;
        unique case (req.op)
            OP_PUSH:
            begin
                if (store_full)
                begin
                    status_c = ST_OVERFLOW;
                end
                else
                begin
                    mem_we = accept;
                    if (req.stack_sel)
                        upper_count_next = upper_count_reg + 1'b1;
                    else
                        lower_count_next = lower_count_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (sel_empty)
                begin
                    status_c = ST_EMPTY;
                end
                else if (req.stack_sel)
                begin
                    upper_count_next = upper_count_reg - 1'b1;
                end
                else
                begin
                    lower_count_next = lower_count_reg - 1'b1;
                end
            end
            default:
            begin
                if (sel_empty)
                    status_c = ST_EMPTY;
            end
        endcase
        new_sel_count = req.stack_sel ? upper_count_next : lower_count_next;
        // Push slot: next free entry on the lower side, or one below the upper top
        waddr_wide = req.stack_sel ? (CAP_C - upper_count_reg - 1'b1) : lower_count_reg;
        // Top of the selected stack after the operation
        raddr_wide = req.stack_sel ? (CAP_C - upper_count_next)
                                   : (lower_count_next - 1'b1);
        waddr  = waddr_wide[AW-1:0];
        raddr  = raddr_wide[AW-1:0];
        mem_re = accept;
    end

    // Store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= req.push_value;
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lower_count_reg <= lower_count_next;
                upper_count_reg <= upper_count_next;
                busy_reg        <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Pending request payload, held while the read completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_c;
            pend_fwd_reg    <= mem_we;
            pend_zero_reg   <= (new_sel_count == '0);
            pend_value_reg  <= req.push_value;
        end
    end

    // Response beat: the pushed value is forwarded, an empty stack reads as zero
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg      <= pend_status_reg;
            out_lower_empty_reg <= (lower_count_reg == '0);
            out_upper_empty_reg <= (upper_count_reg == '0);
            out_full_reg        <= (({1'b0, lower_count_reg} + {1'b0, upper_count_reg})
                                    >= CAP_SUM);
            if (pend_zero_reg)
                out_top_reg <= '0;
            else if (pend_fwd_reg)
                out_top_reg <= pend_value_reg;
            else
                out_top_reg <= rdata_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.top_value   = out_top_reg;
    assign rsp.lower_empty = out_lower_empty_reg;
    assign rsp.upper_empty = out_upper_empty_reg;
    assign rsp.store_full  = out_full_reg;

`ifndef NO_ASSERTIONS
    // The two stacks never hold more than the store
    a_no_overcommit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, lower_count_reg} + {1'b0, upper_count_reg}) <= CAP_SUM)
        else $error("stack counts exceed capacity");

    // An accepted beat occupies the unit in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted beat not held as pending");

    // Counts change only when a beat is accepted
    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(lower_count_reg) && $stable(upper_count_reg)))
        else $error("stack counts changed without a request");

    // An empty-stack response always carries a zero top value
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.top_value == '0))
        else $error("empty status with non-zero top value");

    // A full store never reports both stacks empty
    a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.store_full) |-> !(rsp.lower_empty && rsp.upper_empty))
        else $error("full store reported with both stacks empty");
`endif

endmodule

### tb/sv/dual_stack_shared_array_unit_checker.sv
// Passive checker for the dual stack shared array unit.
// Watches both channels, predicts each response beat and compares it field by field.
// Depends on dssa_pkg and the channel interfaces in dssa_if.sv.
module dual_stack_shared_array_unit_checker #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dssa_req_if         req,
    dssa_rsp_if         rsp,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned overflow_hits,
    output int unsigned empty_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    import dssa_pkg::*;

    localparam int DEPTH_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        status_t status;
        data_t   top_value;
        logic    lower_empty;
        logic    upper_empty;
        logic    store_full;
    } stack_resp_t;

    // Shadow copy of the shared store and the two stack depths.
    data_t              shadow_store [CAPACITY];
    logic [DEPTH_W-1:0] lower_depth;
    logic [DEPTH_W-1:0] upper_depth;

    stack_resp_t        expected_q [$];
    stack_resp_t        want;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, exp_val);
        fail_count++;
    endtask

    // Applies one request to the shadow stacks and returns the response it should give.
    function automatic stack_resp_t apply_stack_op(input op_t op, input logic sel,
                                                   input data_t value);
        stack_resp_t r;
        logic        full;
        logic        sel_empty;
        r.status = ST_OK;
        full = (int'(lower_depth) + int'(upper_depth)) >= CAPACITY;
        sel_empty = sel ? (upper_depth == 0) : (lower_depth == 0);
        if (op == OP_PUSH) begin
            if (full) begin
                r.status = ST_OVERFLOW;
            end
            else if (!sel) begin
                shadow_store[lower_depth] = value;
                lower_depth++;
            end
            else begin
                upper_depth++;
                shadow_store[CAPACITY - int'(upper_depth)] = value;
            end
        end
        else if (sel_empty) begin
            // Pop or peek (the spare code behaves as a peek) on an empty stack.
            r.status = ST_EMPTY;
        end
        else if (op == OP_POP) begin
            if (!sel)
                lower_depth--;
            else
                upper_depth--;
        end

        if (!sel)
            r.top_value = (lower_depth == 0) ? '0 : shadow_store[int'(lower_depth) - 1];
        else
            r.top_value = (upper_depth == 0) ? '0 : shadow_store[CAPACITY - int'(upper_depth)];
        r.lower_empty = (lower_depth == 0);
        r.upper_empty = (upper_depth == 0);
        r.store_full  = (int'(lower_depth) + int'(upper_depth)) >= CAPACITY;

        if (r.status == ST_OVERFLOW)
            overflow_hits++;
        if (r.status == ST_EMPTY)
            empty_hits++;
        return r;
    endfunction

    // Compare response beats against the oldest prediction, then record new requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_depth   = '0;
            upper_depth   = '0;
            fail_count    = 0;
            pending       = 0;
            overflow_hits = 0;
            empty_hits    = 0;
            expected_q.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("response beat with nothing expected",
                                    rsp.top_value, 'x);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.top_value !== want.top_value)
                        report_mismatch("top_value", rsp.top_value, want.top_value);
                    if (rsp.lower_empty !== want.lower_empty)
                        report_mismatch("lower_empty", 32'(rsp.lower_empty),
                                        32'(want.lower_empty));
                    if (rsp.upper_empty !== want.upper_empty)
                        report_mismatch("upper_empty", 32'(rsp.upper_empty),
                                        32'(want.upper_empty));
                    if (rsp.store_full !== want.store_full)
                        report_mismatch("store_full", 32'(rsp.store_full),
                                        32'(want.store_full));
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(apply_stack_op(req.op, req.stack_sel, req.push_value));
            pending = expected_q.size();
        end
    end

endmodule

### tb/sv/dual_stack_shared_array_unit_tb.sv
// Top level of the dual stack shared array unit testbench.
// Drives requests and response back-pressure, runs a watchdog and gives the verdict.
// Depends on dssa_pkg, dssa_if.sv, the unit itself and the checker module.
module dual_stack_shared_array_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dssa_pkg::*;

    localparam int  CAPACITY       = 16;
    localparam int  RANDOM_ITEMS   = 2000;
    localparam int  IDLE_PERCENT   = 16;
    localparam int  QUIET_LO       = 1000;
    localparam int  QUIET_HI       = 1300;
    localparam int  HOLD_AT_BEAT   = 500;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  DRAIN_CYCLES   = 8;

    // The fourth op code has no name in the package; the unit treats it as a peek.
    localparam op_t   OP_SPARE = 2'd3;

    localparam data_t DATA_MIN = 32'h8000_0000;
    localparam data_t DATA_MAX = 32'h7FFF_FFFF;

    logic        clk;
    logic        rst_n;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned overflow_hits;
    int unsigned empty_hits;

    int unsigned sent_count;
    int unsigned push_count;
    int unsigned pop_count;
    int unsigned peek_count;

    dssa_req_if req_ch ();
    dssa_rsp_if rsp_ch ();

    dual_stack_shared_array_unit #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dual_stack_shared_array_unit_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .overflow_hits (overflow_hits),
        .empty_hits    (empty_hits)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly random push values, with the extremes mixed in often.
    function automatic data_t pick_value();
        data_t v;
        v = data_t'($urandom);
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: v = DATA_MIN;
                1: v = DATA_MAX;
                2: v = '0;
                default: v = '1;
            endcase
        end
        return v;
    endfunction

    // Offers one request beat, with random idle cycles ahead of it, and waits for acceptance.
    task automatic send_request(input op_t op, input logic sel, input data_t value);
        bit quiet;
        quiet = (sent_count >= QUIET_LO) && (sent_count < QUIET_HI);
        while (!quiet && ($urandom_range(99) < IDLE_PERCENT))
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.stack_sel  <= sel;
        req_ch.push_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_count++;
        if (op == OP_PUSH)
            push_count++;
        else if (op == OP_POP)
            pop_count++;
        else
            peek_count++;
    endtask

    // Response side: random back-pressure, one long hold-off and a quiet window.
    initial
    begin
        int unsigned beats;
        bit          held;
        beats = 0;
        held  = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                beats++;
            if (!held && beats >= HOLD_AT_BEAT)
            begin
                // Hold off long enough for the unit to fill and stall its request side.
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (beats >= QUIET_LO && beats < QUIET_HI)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: ends the run when nothing is accepted on either channel for too long.
    initial
    begin
        int unsigned stalled;
        stalled = 0;
        @(posedge rst_n);
        while (stalled < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("watchdog expired after %0d cycles without a beat", WATCHDOG_LIMIT);
        $display("** dual_stack_shared_array_unit: FAILED **");
        $finish;
    end

    // Reset, directed requests, random phases, drain and verdict.
    initial
    begin
        int          n;
        int          len;
        int          mode;
        int          sel_bias;
        int          r;
        op_t         op;
        sent_count = 0;
        push_count = 0;
        pop_count  = 0;
        peek_count = 0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= OP_PUSH;
        req_ch.stack_sel  <= 1'b0;
        req_ch.push_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stacks: pops and peeks give the empty status and a zero top.
        send_request(OP_POP,   1'b0, pick_value());
        send_request(OP_POP,   1'b1, pick_value());
        send_request(OP_PEEK,  1'b0, pick_value());
        send_request(OP_SPARE, 1'b1, pick_value());

        // Extreme values on both stacks, then pops that leave each stack empty.
        send_request(OP_PUSH,  1'b0, DATA_MIN);
        send_request(OP_PUSH,  1'b1, DATA_MAX);
        send_request(OP_PEEK,  1'b0, '1);
        send_request(OP_SPARE, 1'b1, '0);
        send_request(OP_POP,   1'b0, pick_value());
        send_request(OP_POP,   1'b1, pick_value());

        // Fill the whole store from the lower stack, then push into a full store
        // while the upper stack is empty and again on the lower stack.
        for (n = 0; n < CAPACITY; n++)
            send_request(OP_PUSH, 1'b0, (n == 0) ? DATA_MAX : pick_value());
        send_request(OP_PUSH, 1'b1, DATA_MIN);
        send_request(OP_PUSH, 1'b0, '1);

        // Random phases: fill-heavy, drain-heavy and mixed runs with a stack bias.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode     = $urandom_range(2);
            len      = $urandom_range(8, 48);
            sel_bias = $urandom_range(100);
            repeat (len)
            begin
                r = $urandom_range(99);
                case (mode)
                    0:       op = (r < 70) ? OP_PUSH : (r < 85) ? OP_POP :
                                  (r < 97) ? OP_PEEK : OP_SPARE;
                    1:       op = (r < 15) ? OP_PUSH : (r < 75) ? OP_POP :
                                  (r < 95) ? OP_PEEK : OP_SPARE;
                    default: op = (r < 40) ? OP_PUSH : (r < 75) ? OP_POP :
                                  (r < 95) ? OP_PEEK : OP_SPARE;
                endcase
                send_request(op, ($urandom_range(99) < sel_bias), pick_value());
                n++;
            end
        end
        req_ch.valid <= 1'b0;

        // Let the checker record the last request, wait for every predicted
        // response, then let the pipeline settle.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d pushes, %0d pops, %0d peeks, with one long stall.",
                 sent_count, push_count, pop_count, peek_count);
        $display("Predicted %0d overflow and %0d empty-stack responses.",
                 overflow_hits, empty_hits);
        if (fail_count == 0)
            $display("** dual_stack_shared_array_unit: PASSED **");
        else
            $display("** dual_stack_shared_array_unit: FAILED **");
        $finish;
    end

endmodule

### dual_stack_shared_array_unit.f
design/dssa_pkg.sv
design/dssa_if.sv
design/dual_stack_shared_array_unit.sv
tb/sv/dual_stack_shared_array_unit_checker.sv
tb/sv/dual_stack_shared_array_unit_tb.sv
